FILE: src/cfr_pkg.sv
// Package for the find-character occurrence ranker.
// Holds the shared widths, register indexes and the structs passed between modules.
// No dependencies.
package cfr_pkg;

    // Line and alphabet sizes.
    localparam int LINE_MAX = 1024;
    localparam int ALPHABET = 256;

    // Field widths.
    localparam int CH_W  = 8;
    localparam int COL_W = $clog2(LINE_MAX);
    localparam int LEN_W = COL_W + 1;
    localparam int POS_W = 11;
    localparam int CNT_W = 10;
    localparam int IDX_W = $clog2(ALPHABET);

    // Signed working width for columns: holds cursor +/- 1 +/- scan position.
    localparam int SCOL_W = POS_W + 2;

    // Saturation limits.
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = LEN_W;

    // Result queue.
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = 2;

    // Register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CURSOR_COL    = 3'd0,
        REG_TARGET_COL    = 3'd1,
        REG_WINDOW_RADIUS = 3'd2,
        REG_LINE_LENGTH   = 3'd3,
        REG_SCAN_FORWARD  = 3'd4
    } t_cfg_reg;

    // Configuration register contents.
    typedef struct packed {
        logic [COL_W-1:0] cursor_col;
        logic [COL_W-1:0] target_col;
        logic [COL_W-1:0] window_radius;
        logic [LEN_W-1:0] line_length;
        logic             scan_forward;
    } t_cfg;

    // Window bounds latched at scan start.
    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] low;
        logic [COL_W-1:0] high;
    } t_window;

    // Item in the count stage.
    typedef struct packed {
        logic                     valid;
        logic [CH_W-1:0]          ch;
        logic                     start;
        logic signed [SCOL_W-1:0] col;
        logic                     fwd;
    } t_stage;

    // One result word.
    typedef struct packed {
        logic [CH_W-1:0]  out_ch;
        logic [COL_W-1:0] column;
        logic [CNT_W-1:0] earlier_count;
        logic             last;
    } t_result;

endpackage

FILE: src/cfr_if.sv
// Channel interfaces of the find-character occurrence ranker.
// Depends on cfr_pkg for field widths.

// Input channel: one line byte per word.
interface cfr_in_if;
    logic                     valid;
    logic                     ready;
    logic [cfr_pkg::CH_W-1:0] ch;
    logic                     start_req;

    modport source (output valid, ch, start_req, input ready);
    modport sink   (input valid, ch, start_req, output ready);
endinterface

// Output channel: one ranked window character per word.
interface cfr_out_if;
    logic                      valid;
    logic                      ready;
    logic [cfr_pkg::CH_W-1:0]  out_ch;
    logic [cfr_pkg::COL_W-1:0] column;
    logic [cfr_pkg::CNT_W-1:0] earlier_count;
    logic                      last;

    modport source (output valid, out_ch, column, earlier_count, last, input ready);
    modport sink   (input valid, out_ch, column, earlier_count, last, output ready);
endinterface

// Configuration write channel.
interface cfr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cfr_pkg::CFG_IDX_W-1:0]  index;
    logic [cfr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/char_find_occurrence_ranker.sv
// Find-character occurrence ranker: top level.
// Channels: i_cfg writes the five registers (cursor column, target column, window
// radius, line length, scan direction) by index; it is always ready. i_in takes one
// line byte per word in scan order, beginning next to the cursor, with start_req set
// on the first byte of a scan. o_out gives one word for each byte that falls inside
// the window: the byte, its column, how often it appeared earlier in the scan, and
// last at the window's far edge. Bytes outside the window give no word.
// Timing: an accepted byte is registered in the count stage, and its result word is
// then pushed into the queue that drives o_out. One byte per cycle is taken while
// i_in.ready is high; each byte makes one count RAM read at acceptance and, if in or
// before the window and unsaturated, a write in the next cycle; the last write is forwarded.
// Stalls: results wait in a three-word queue; i_in.ready drops once the queue words
// plus the byte in the count stage reach three, so a stalled receiver stops intake.
// Reset: registers return to cursor 0, target 0, radius 0, length 1, forward scan;
// the window is empty and the count table reads as zero until the first start.
// Depends on cfr_pkg, cfr_if, cfr_ram, cfr_cfg, cfr_count and cfr_out_fifo.
module char_find_occurrence_ranker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cfr_cfg_if.sink    i_cfg,
    cfr_in_if.sink     i_in,
    cfr_out_if.source  o_out
);

    cfr_pkg::t_cfg    cfg;
    cfr_pkg::t_window win_calc;
    cfr_pkg::t_window r_win;
    cfr_pkg::t_window n_win;
    cfr_pkg::t_stage  r_s1;
    cfr_pkg::t_stage  n_s1;
    logic [cfr_pkg::POS_W-1:0]      r_pos;
    logic [cfr_pkg::POS_W-1:0]      n_pos;
    logic [cfr_pkg::POS_W-1:0]      pos_use;
    logic [cfr_pkg::FIFO_PTR_W-1:0] occ;
    logic                           accept;
    logic                           push;
    cfr_pkg::t_result               res;
    logic signed [cfr_pkg::SCOL_W-1:0] cur;
    logic signed [cfr_pkg::SCOL_W-1:0] pos_s;

    cfr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg),
        .o_win   (win_calc)
    );

    // Intake is allowed while the queue has room for every word in flight.
    assign i_in.ready = ((cfr_pkg::FIFO_PTR_W + 1)'(occ) + (cfr_pkg::FIFO_PTR_W + 1)'(r_s1.valid))
                        < (cfr_pkg::FIFO_PTR_W + 1)'(cfr_pkg::FIFO_DEPTH);
    assign accept     = i_in.valid && i_in.ready;

    // Column of the incoming byte from the cursor and the scan position.
    always_comb begin
        pos_use = i_in.start_req ? '0 : r_pos;
        cur     = $signed(cfr_pkg::SCOL_W'(cfg.cursor_col));
        pos_s   = $signed(cfr_pkg::SCOL_W'(pos_use));
        n_s1.valid = accept;
        n_s1.ch    = i_in.ch;
        n_s1.start = i_in.start_req;
        n_s1.fwd   = cfg.scan_forward;
        n_s1.col   = cfg.scan_forward ? (cur + 1 + pos_s) : (cur - 1 - pos_s);
    end

    // Scan position saturates; the window is captured on a start word.
    always_comb begin
        n_pos = r_pos;
        n_win = r_win;
        if (accept) begin
            n_pos = (pos_use == cfr_pkg::POS_MAX) ? pos_use : pos_use + cfr_pkg::POS_W'(1);
            if (i_in.start_req) begin
                n_win = win_calc;
            end
        end
    end

    // State registers; the count stage payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_win.valid <= 1'b0;
            r_win.low   <= '0;
            r_win.high  <= '0;
            r_s1.valid  <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_win      <= n_win;
            r_s1.valid <= n_s1.valid;
        end
        r_s1.ch    <= n_s1.ch;
        r_s1.start <= n_s1.start;
        r_s1.fwd   <= n_s1.fwd;
        r_s1.col   <= n_s1.col;
    end

    cfr_count u_count (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (i_in.ch[cfr_pkg::IDX_W-1:0]),
        .i_s1      (r_s1),
        .i_win     (r_win),
        .o_push    (push),
        .o_res     (res)
    );

    cfr_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .o_out   (o_out),
        .o_occ   (occ)
    );

    // A result only comes from a byte in the count stage.
    a_push_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> r_s1.valid)
        else $error("result without a byte in the count stage");

    // An accepted byte occupies the count stage in the next cycle.
    a_stage_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1.valid)
        else $error("accepted byte missing from count stage");

    // A valid window is never inverted.
    a_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_win.valid |-> (r_win.low <= r_win.high))
        else $error("window bounds inverted");

endmodule

FILE: src/cfr_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; a read of the entry being written returns the old data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/cfr_cfg.sv
// Configuration registers and window computation of the occurrence ranker.
// Depends on cfr_pkg and cfr_if.
module cfr_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cfr_cfg_if.sink           i_cfg,
    output cfr_pkg::t_cfg     o_cfg,
    output cfr_pkg::t_window  o_win
);

    cfr_pkg::t_cfg r_cfg;
    cfr_pkg::t_cfg n_cfg;

    logic signed [cfr_pkg::SCOL_W-1:0] cur;
    logic signed [cfr_pkg::SCOL_W-1:0] tgt;
    logic signed [cfr_pkg::SCOL_W-1:0] len;
    logic signed [cfr_pkg::SCOL_W-1:0] ct_dist;
    logic signed [cfr_pkg::SCOL_W-1:0] thr;
    logic signed [cfr_pkg::SCOL_W-1:0] lo;
    logic signed [cfr_pkg::SCOL_W-1:0] hi;
    logic signed [cfr_pkg::SCOL_W-1:0] lo_c;
    logic signed [cfr_pkg::SCOL_W-1:0] hi_c;

    // The port takes a word in every cycle.
    assign i_cfg.ready = 1'b1;

    // Register write decode; unknown indexes are dropped.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (cfr_pkg::t_cfg_reg'(i_cfg.index))
                cfr_pkg::REG_CURSOR_COL:    n_cfg.cursor_col    = i_cfg.data[cfr_pkg::COL_W-1:0];
                cfr_pkg::REG_TARGET_COL:    n_cfg.target_col    = i_cfg.data[cfr_pkg::COL_W-1:0];
                cfr_pkg::REG_WINDOW_RADIUS: n_cfg.window_radius = i_cfg.data[cfr_pkg::COL_W-1:0];
                cfr_pkg::REG_LINE_LENGTH:   n_cfg.line_length   = i_cfg.data[cfr_pkg::LEN_W-1:0];
                cfr_pkg::REG_SCAN_FORWARD:  n_cfg.scan_forward  = i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cursor_col    <= '0;
            r_cfg.target_col    <= '0;
            r_cfg.window_radius <= '0;
            r_cfg.line_length   <= cfr_pkg::LEN_W'(1);
            r_cfg.scan_forward  <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Window around the target: radius limited to the cursor distance, then clipped
    // to the line and to the scanned side of the cursor.
    always_comb begin
        cur = $signed(cfr_pkg::SCOL_W'(r_cfg.cursor_col));
        tgt = $signed(cfr_pkg::SCOL_W'(r_cfg.target_col));
        if (r_cfg.line_length > cfr_pkg::LEN_W'(cfr_pkg::LINE_MAX)) begin
            len = cfr_pkg::SCOL_W'(cfr_pkg::LINE_MAX);
        end else begin
            len = $signed(cfr_pkg::SCOL_W'(r_cfg.line_length));
        end
        ct_dist = (cur > tgt) ? (cur - tgt) : (tgt - cur);
        thr  = $signed(cfr_pkg::SCOL_W'(r_cfg.window_radius));
        if (thr > ct_dist) begin
            thr = ct_dist;
        end
        lo = tgt - thr;
        if (lo < 0) begin
            lo = '0;
        end
        hi = tgt + thr;
        if (hi > len - 1) begin
            hi = len - 1;
        end
        lo_c = lo;
        hi_c = hi;
        if (r_cfg.scan_forward) begin
            if (lo_c < cur + 1) begin
                lo_c = cur + 1;
            end
        end else begin
            if (hi_c > cur - 1) begin
                hi_c = cur - 1;
            end
        end
        if (lo_c > hi_c) begin
            o_win.valid = 1'b0;
            o_win.low   = '0;
            o_win.high  = '0;
        end else begin
            o_win.valid = 1'b1;
            o_win.low   = lo_c[cfr_pkg::COL_W-1:0];
            o_win.high  = hi_c[cfr_pkg::COL_W-1:0];
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/cfr_count.sv
// Count stage of the occurrence ranker: per-byte count RAM with read-modify-write,
// forwarding of the previous write, and per-entry valid bits cleared at scan start.
// Depends on cfr_pkg and cfr_ram.
module cfr_count (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [cfr_pkg::IDX_W-1:0]  i_rd_addr,
    input  cfr_pkg::t_stage            i_s1,
    input  cfr_pkg::t_window           i_win,
    output logic                       o_push,
    output cfr_pkg::t_result           o_res
);

    logic [cfr_pkg::ALPHABET-1:0] r_vld;
    logic [cfr_pkg::ALPHABET-1:0] n_vld;
    logic                         r_fwd_v;
    logic [cfr_pkg::IDX_W-1:0]    r_fwd_idx;
    logic [cfr_pkg::CNT_W-1:0]    r_fwd_val;

    logic [cfr_pkg::IDX_W-1:0]    idx;
    logic [cfr_pkg::CNT_W-1:0]    ram_q;
    logic [cfr_pkg::CNT_W-1:0]    old_cnt;
    logic [cfr_pkg::CNT_W-1:0]    new_cnt;
    logic signed [cfr_pkg::SCOL_W-1:0] lo;
    logic signed [cfr_pkg::SCOL_W-1:0] hi;
    logic                         win_ok;
    logic                         in_win;
    logic                         ahead;
    logic                         do_write;

    assign idx = i_s1.ch[cfr_pkg::IDX_W-1:0];

    cfr_ram #(
        .WIDTH (cfr_pkg::CNT_W),
        .DEPTH (cfr_pkg::ALPHABET)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (idx),
        .i_wdata (new_cnt),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (ram_q)
    );

    // Current count: zero at scan start, the word written last cycle if it hit the
    // same entry, else the RAM word when the entry was written in this scan.
    always_comb begin
        if (i_s1.start) begin
            old_cnt = '0;
        end else if (r_fwd_v && (r_fwd_idx == idx)) begin
            old_cnt = r_fwd_val;
        end else if (r_vld[idx]) begin
            old_cnt = ram_q;
        end else begin
            old_cnt = '0;
        end
        new_cnt = old_cnt + cfr_pkg::CNT_W'(1);
    end

    // Classify the column against the window.
    always_comb begin
        lo     = $signed(cfr_pkg::SCOL_W'(i_win.low));
        hi     = $signed(cfr_pkg::SCOL_W'(i_win.high));
        win_ok = i_s1.valid && i_win.valid && (i_s1.col >= 0);
        in_win = (i_s1.col >= lo) && (i_s1.col <= hi);
        ahead  = i_s1.fwd ? (i_s1.col < lo) : (i_s1.col > hi);
        do_write = win_ok && (in_win || ahead) && (old_cnt != cfr_pkg::CNT_MAX);
    end

    // Result word for a window character.
    always_comb begin
        o_push               = win_ok && in_win;
        o_res.out_ch         = i_s1.ch;
        o_res.column         = i_s1.col[cfr_pkg::COL_W-1:0];
        o_res.earlier_count  = old_cnt;
        o_res.last           = i_s1.fwd ? (i_s1.col == hi) : (i_s1.col == lo);
    end

    // Valid bits: all cleared by a start word, then the written entry is marked.
    always_comb begin
        n_vld = r_vld;
        if (i_s1.valid && i_s1.start) begin
            n_vld = '0;
        end
        if (do_write) begin
            n_vld[idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_fwd_v <= 1'b0;
        end else begin
            r_vld   <= n_vld;
            r_fwd_v <= do_write;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_idx <= idx;
        r_fwd_val <= new_cnt;
    end

    // A start word always sees an empty table.
    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && i_s1.start) |-> (o_res.earlier_count == '0))
        else $error("start word reported a nonzero earlier count");

    // After a start word only its own entry can be valid.
    a_start_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s1.valid && i_s1.start) |=> $onehot0(r_vld))
        else $error("valid bits not cleared by start word");

    // Counts never wrap to zero.
    a_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_write |-> (new_cnt != '0))
        else $error("count wrapped");

    // A written entry is valid in the next cycle.
    a_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_write |=> r_vld[$past(idx)])
        else $error("written entry not marked valid");

endmodule

FILE: src/cfr_out_fifo.sv
// Three-word result queue of the occurrence ranker, driving the output channel.
// Depends on cfr_pkg and cfr_if.
module cfr_out_fifo (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  cfr_pkg::t_result               i_res,
    cfr_out_if.source                      o_out,
    output logic [cfr_pkg::FIFO_PTR_W-1:0] o_occ
);

    cfr_pkg::t_result r_mem [cfr_pkg::FIFO_DEPTH];
    logic [cfr_pkg::FIFO_PTR_W-1:0] r_wr;
    logic [cfr_pkg::FIFO_PTR_W-1:0] n_wr;
    logic [cfr_pkg::FIFO_PTR_W-1:0] r_rd;
    logic [cfr_pkg::FIFO_PTR_W-1:0] n_rd;
    logic [cfr_pkg::FIFO_PTR_W-1:0] r_cnt;
    logic [cfr_pkg::FIFO_PTR_W-1:0] n_cnt;
    logic                           pop;
    cfr_pkg::t_result               head;

    assign head           = r_mem[r_rd];
    assign o_out.valid    = (r_cnt != '0);
    assign o_out.out_ch   = head.out_ch;
    assign o_out.column   = head.column;
    assign o_out.earlier_count = head.earlier_count;
    assign o_out.last     = head.last;
    assign pop            = o_out.valid && o_out.ready;
    assign o_occ          = r_cnt;

    // Pointer and fill updates, pointers wrap at the queue depth.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == cfr_pkg::FIFO_PTR_W'(cfr_pkg::FIFO_DEPTH - 1)) ?
                   '0 : r_wr + cfr_pkg::FIFO_PTR_W'(1);
        end
        if (pop) begin
            n_rd = (r_rd == cfr_pkg::FIFO_PTR_W'(cfr_pkg::FIFO_DEPTH - 1)) ?
                   '0 : r_rd + cfr_pkg::FIFO_PTR_W'(1);
        end
        if (i_push && !pop) begin
            n_cnt = r_cnt + cfr_pkg::FIFO_PTR_W'(1);
        end else if (pop && !i_push) begin
            n_cnt = r_cnt - cfr_pkg::FIFO_PTR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_res;
        end
    end

    // The input side throttles early enough that a push never meets a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt < cfr_pkg::FIFO_PTR_W'(cfr_pkg::FIFO_DEPTH)))
        else $error("result pushed into full queue");

    // Fill level stays within the depth.
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= cfr_pkg::FIFO_PTR_W'(cfr_pkg::FIFO_DEPTH))
        else $error("queue fill out of range");

    // Pointers agree with the fill level when the queue is empty.
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_rd == r_wr))
        else $error("pointers disagree on an empty queue");

endmodule
